[rtl/core/lz77d_pkg.sv]
// Package for the LZ77 token decompressor core: shared constants and types.
// Used by the controller, the datapath and the top level.
`timescale 1ns / 1ps

package lz77d_pkg;

    localparam int HISTORY_DEPTH_DEF = 4096;
    localparam int BEAT_BYTES_DEF    = 8;
    localparam int LW_WIDTH          = 4;
    localparam int SIZE_WIDTH        = 24;
    localparam int WORD_WIDTH        = 16;
    localparam int CFG_IDX_WIDTH     = 1;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_LENGTH_WIDTH = 1'b0;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_STREAM_SIZE  = 1'b1;
    localparam logic [LW_WIDTH-1:0] LW_MIN   = 4'd4;
    localparam logic [LW_WIDTH-1:0] LW_MAX   = 4'd8;
    localparam logic [LW_WIDTH-1:0] LW_RESET = 4'd8;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RUN,
        ST_FLUSH
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic start;   // latch token
        logic step;    // produce one byte, or read the ring for a copy byte
        logic flush;   // present the token's last beat
        logic clr_en;  // clear one ring entry
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic clr_done;
        logic tok_end;    // token ends with this step (last byte, or stream already ended)
        logic beat_busy;  // output register holds an untaken beat
        logic beat_full;  // accumulator holds a full beat
    } stat_t;

endpackage

[rtl/core/lz77_token_decompressor_core.sv]
// LZ77 token decompressor core. A token is accepted in IDLE, its bytes are made
// in RUN and FLUSH presents its last beat. Each copied byte takes a ring read
// then a write (one ring read port); each held beat stalls the token once the
// packer fills.
// Reset: synchronous active low; a clearing pass zeroes all HISTORY_DEPTH ring
// entries (4096 at default), during which no token is accepted.
`timescale 1ns / 1ps

module lz77_token_decompressor_core #(
    parameter int HISTORY_DEPTH = lz77d_pkg::HISTORY_DEPTH_DEF,
    parameter int BEAT_BYTES    = lz77d_pkg::BEAT_BYTES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // slave: pointer_word[15:0], literal_byte[23:16]
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,
    // master: data_bytes[63:0], byte_count[67:64], pad to 72
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,
    output logic        m_tlast,   // token_done
    // m_tuser: stream_done[0], overrun[1]
    output logic [1:0]  m_tuser,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [23:0] cfg_wdata
);

    logic [3:0]  lw_reg;
    logic [23:0] size_reg;
    lz77d_pkg::cmd_t  cmd;
    lz77d_pkg::stat_t stat;
    logic [63:0] data;
    logic [3:0]  cnt;

    // hold configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lw_reg   <= lz77d_pkg::LW_RESET;
            size_reg <= 24'd1;
        end else if (cfg_we) begin
            case (cfg_index)
                lz77d_pkg::CFG_LENGTH_WIDTH: lw_reg   <= cfg_wdata[3:0];
                lz77d_pkg::CFG_STREAM_SIZE:  size_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    lz77d_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_tvalid), .in_ready(s_tready),
        .stat(stat), .cmd(cmd)
    );

    lz77d_datapath #(
        .HISTORY_DEPTH(HISTORY_DEPTH), .BEAT_BYTES(BEAT_BYTES)
    ) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .stat(stat),
        .word(s_tdata[15:0]), .lit(s_tdata[23:16]),
        .lw_cfg(lw_reg), .size_cfg(size_reg),
        .out_valid(m_tvalid), .out_ready(m_tready),
        .out_data(data), .out_count(cnt),
        .out_tok_done(m_tlast), .out_str_done(m_tuser[0]),
        .out_overrun(m_tuser[1])
    );

    assign m_tdata = {4'd0, cnt, data};

    // a beat never carries zero bytes
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (cnt != 4'd0)) else $error("empty beat");
    // stream end and overrun only on a token's last beat
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser != 2'b00)) |-> m_tlast) else $error("flag off last beat");
    // no token taken while a token is in flight
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready) else $error("double accept");

endmodule

[rtl/core/lz77d_ctrl.sv]
// Controller for the LZ77 token decompressor: clear pass, token sequencing.
// Depends on lz77d_pkg.
`timescale 1ns / 1ps

module lz77d_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  lz77d_pkg::stat_t stat,
    output lz77d_pkg::cmd_t  cmd
);

    lz77d_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= lz77d_pkg::ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            lz77d_pkg::ST_CLEAR: begin
                cmd.clr_en = 1'b1;
                if (stat.clr_done) state_next = lz77d_pkg::ST_IDLE;
            end
            lz77d_pkg::ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.start  = 1'b1;
                    state_next = lz77d_pkg::ST_RUN;
                end
            end
            lz77d_pkg::ST_RUN: begin
                // stall while a full beat waits for the sink
                if (!(stat.beat_busy && stat.beat_full)) begin
                    cmd.step = 1'b1;
                    if (stat.tok_end) state_next = lz77d_pkg::ST_FLUSH;
                end
            end
            lz77d_pkg::ST_FLUSH: begin
                if (!stat.beat_busy) begin
                    cmd.flush  = 1'b1;
                    state_next = lz77d_pkg::ST_IDLE;
                end
            end
            default: state_next = lz77d_pkg::ST_IDLE;
        endcase
    end

endmodule

[rtl/core/lz77d_datapath.sv]
// Datapath for the LZ77 token decompressor: history ring, counters, beat packer.
// Depends on lz77d_pkg.
`timescale 1ns / 1ps

module lz77d_datapath #(
    parameter int HISTORY_DEPTH = lz77d_pkg::HISTORY_DEPTH_DEF,
    parameter int BEAT_BYTES    = lz77d_pkg::BEAT_BYTES_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  lz77d_pkg::cmd_t                     cmd,
    output lz77d_pkg::stat_t                    stat,
    input  logic [lz77d_pkg::WORD_WIDTH-1:0]    word,
    input  logic [7:0]                          lit,
    input  logic [lz77d_pkg::LW_WIDTH-1:0]      lw_cfg,
    input  logic [lz77d_pkg::SIZE_WIDTH-1:0]    size_cfg,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [63:0]                         out_data,
    output logic [3:0]                          out_count,
    output logic                                out_tok_done,
    output logic                                out_str_done,
    output logic                                out_overrun
);

    localparam int AW = $clog2(HISTORY_DEPTH);
    localparam int CW = $clog2(BEAT_BYTES + 1);
    localparam int BW = (BEAT_BYTES > 1) ? $clog2(BEAT_BYTES) : 1;
    localparam int DW = lz77d_pkg::WORD_WIDTH - 3;  // distance up to 12 bits
    localparam int SW = lz77d_pkg::SIZE_WIDTH;

    logic [7:0]    ring [HISTORY_DEPTH];
    logic [AW-1:0] wr_idx_reg;
    logic [AW-1:0] clr_idx_reg;
    logic [SW-1:0] emitted_reg;
    logic [SW-1:0] size_reg;
    logic [DW:0]   dist_reg;
    logic          dist_far_reg;
    logic [8:0]    run_reg;      // bytes left of the copy
    logic [7:0]    lit_reg;
    logic          ended_reg, dropped_reg;
    logic [7:0]    rd_data;
    logic [AW-1:0] rd_addr;
    logic [7:0]    acc_data_reg [BEAT_BYTES];
    logic [CW-1:0] acc_cnt_reg;
    logic [BW-1:0] acc_idx;
    logic          copy_ok_reg;  // read data of the current copy byte is valid
    logic [63:0]   od_reg;
    logic [3:0]    oc_reg;
    logic          ov_reg, otd_reg, osd_reg, oo_reg;

    // decode the token
    logic [3:0]  lw;
    logic [15:0] dist_w;
    logic [8:0]  len_w;
    always_comb begin
        lw = lw_cfg;
        if (lw < lz77d_pkg::LW_MIN) lw = lz77d_pkg::LW_MIN;
        if (lw > lz77d_pkg::LW_MAX) lw = lz77d_pkg::LW_MAX;
        dist_w = word >> lw;
        len_w  = 9'((word & ((16'd1 << lw) - 16'd1))) + 9'd1;
    end

    // a step makes one byte, but a copy byte needs a ring read step first
    logic       is_copy, can_make, produce, last_byte;
    logic [7:0] byte_val;
    assign is_copy   = (run_reg != 9'd0);
    assign can_make  = !ended_reg && (!is_copy || copy_ok_reg);
    assign produce   = cmd.step && can_make;
    assign byte_val  = is_copy ? (dist_far_reg ? 8'd0 : rd_data) : lit_reg;
    assign last_byte = !is_copy;
    assign rd_addr   = wr_idx_reg - AW'(dist_reg);
    assign acc_idx   = (acc_cnt_reg == CW'(BEAT_BYTES)) ? '0 : BW'(acc_cnt_reg);

    logic hit_now, stream_hit;
    assign hit_now    = ((emitted_reg + SW'(1)) >= size_reg);
    assign stream_hit = produce && hit_now;

    assign stat.tok_end   = ended_reg || (can_make && (last_byte || hit_now));
    assign stat.beat_busy = ov_reg && !out_ready;
    assign stat.beat_full = (acc_cnt_reg == CW'(BEAT_BYTES));
    assign stat.clr_done  = (clr_idx_reg == AW'(HISTORY_DEPTH - 1));

    always_ff @(posedge aclk) begin
        if (cmd.clr_en) ring[clr_idx_reg] <= 8'd0;
        else if (produce) ring[wr_idx_reg] <= byte_val;
        rd_data <= ring[rd_addr];
    end

    // stream ends on a copy byte: the rest of the token is dropped
    logic dropped_now;
    assign dropped_now = stream_hit && is_copy;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_idx_reg  <= '0;
            clr_idx_reg <= '0;
            emitted_reg <= '0;
            run_reg     <= '0;
            ended_reg   <= 1'b0;
            dropped_reg <= 1'b0;
            acc_cnt_reg <= '0;
            copy_ok_reg <= 1'b0;
            ov_reg      <= 1'b0;
        end else begin
            if (cmd.clr_en) clr_idx_reg <= clr_idx_reg + 1'b1;
            if (out_ready) ov_reg <= 1'b0;
            copy_ok_reg <= 1'b0;
            if (cmd.start) begin
                size_reg     <= (size_cfg == '0) ? SW'(1) : size_cfg;
                if (emitted_reg >= ((size_cfg == '0) ? SW'(1) : size_cfg))
                    emitted_reg <= '0;
                dist_reg     <= (DW+1)'(dist_w);
                dist_far_reg <= ({16'd0, dist_w} > 32'(HISTORY_DEPTH));
                run_reg      <= (dist_w != 16'd0) ? len_w : 9'd0;
                lit_reg      <= lit;
                ended_reg    <= 1'b0;
                dropped_reg  <= 1'b0;
            end else if (cmd.step) begin
                copy_ok_reg <= !produce && is_copy && !ended_reg;
                if (dropped_now) dropped_reg <= 1'b1;
                if (produce) begin
                    wr_idx_reg  <= wr_idx_reg + 1'b1;
                    emitted_reg <= emitted_reg + 1'b1;
                    if (is_copy) run_reg <= run_reg - 9'd1;
                    if (stream_hit) ended_reg <= 1'b1;
                    acc_data_reg[acc_idx] <= byte_val;
                    acc_cnt_reg <= acc_cnt_reg + 1'b1;
                end
                // a full beat leaves for the output register
                if (acc_cnt_reg == CW'(BEAT_BYTES) && !stat.beat_busy) begin
                    ov_reg  <= 1'b1;
                    otd_reg <= 1'b0;
                    osd_reg <= 1'b0;
                    oo_reg  <= 1'b0;
                    oc_reg  <= 4'(BEAT_BYTES);
                    for (int j = 0; j < 8; j++)
                        od_reg[8*j +: 8] <= (j < BEAT_BYTES) ? acc_data_reg[j % BEAT_BYTES]
                                                             : 8'd0;
                    if (produce) begin
                        acc_data_reg[0] <= byte_val;
                        acc_cnt_reg     <= CW'(1);
                    end else begin
                        acc_cnt_reg <= '0;
                    end
                end
            end else if (cmd.flush) begin
                ov_reg  <= 1'b1;
                otd_reg <= 1'b1;
                osd_reg <= ended_reg;
                oo_reg  <= dropped_reg;
                oc_reg  <= 4'(acc_cnt_reg);
                for (int j = 0; j < 8; j++)
                    od_reg[8*j +: 8] <= (j < BEAT_BYTES && CW'(j) < acc_cnt_reg)
                                        ? acc_data_reg[j % BEAT_BYTES] : 8'd0;
                acc_cnt_reg <= '0;
                if (ended_reg) emitted_reg <= '0;
            end
        end
    end

    assign out_valid    = ov_reg;
    assign out_data     = od_reg;
    assign out_count    = oc_reg;
    assign out_tok_done = otd_reg;
    assign out_str_done = osd_reg;
    assign out_overrun  = oo_reg;

endmodule
